[rtl/hed_pkg.sv]
package hed_pkg;

    localparam logic [7:0] IND_EVENT = 8'h04;
    localparam logic [8:0] HDR_LEN = 9'd3;
    localparam logic [8:0] BUF_SIZE_RESET = 9'd258;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_CODE  = 2'd1,
        PH_LEN   = 2'd2,
        PH_PARAM = 2'd3
    } phase_t;

    // One result beat as it travels from the state machine to the output register.
    typedef struct packed {
        logic       valid;
        logic [7:0] packet_byte;
        logic [8:0] byte_position;
        logic       end_of_packet;
        logic [8:0] packet_count;
    } res_t;

endpackage

[rtl/hed_in_stage.sv]
module hed_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       take,
    output logic       hold_valid,
    output logic [7:0] hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       accept;

    // The held byte may leave and a new one enter in the same cycle.
    assign rx_stall   = valid_reg && !take;
    assign accept     = rx_valid && !rx_stall;
    assign valid_next = accept ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

endmodule

[rtl/hed_fsm.sv]
module hed_fsm (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          hold_valid,
    input  logic [7:0]    hold_byte,
    input  logic          out_busy,
    input  logic          cfg_write,
    input  logic [8:0]    cfg_data,
    output logic          take,
    output hed_pkg::res_t res
);

    hed_pkg::phase_t phase_reg;
    hed_pkg::phase_t phase_next;
    logic [8:0]      index_reg;
    logic [8:0]      index_next;
    logic [7:0]      left_reg;
    logic [7:0]      left_next;
    logic [8:0]      bufsize_reg;
    logic [8:0]      cap;
    logic [7:0]      keep;
    logic            has_res;

    assign cap  = (bufsize_reg > hed_pkg::HDR_LEN) ? (bufsize_reg - hed_pkg::HDR_LEN) : 9'd0;
    assign keep = ({1'b0, hold_byte} < cap) ? hold_byte : cap[7:0];

    // Only a non-indicator byte while hunting produces no result.
    assign has_res = (phase_reg != hed_pkg::PH_HUNT) || (hold_byte == hed_pkg::IND_EVENT);
    assign take    = hold_valid && (!has_res || !out_busy);

    always_comb
    begin
        phase_next        = phase_reg;
        index_next        = index_reg;
        left_next         = left_reg;
        res.valid         = take && has_res;
        res.packet_byte   = hold_byte;
        res.byte_position = 9'd0;
        res.end_of_packet = 1'b0;
        res.packet_count  = 9'd0;
        case (phase_reg)
            hed_pkg::PH_HUNT:
            begin
                if (hold_byte == hed_pkg::IND_EVENT)
                begin
                    index_next = 9'd1;
                    phase_next = hed_pkg::PH_CODE;
                end
            end
            hed_pkg::PH_CODE:
            begin
                res.byte_position = 9'd1;
                index_next        = 9'd2;
                phase_next        = hed_pkg::PH_LEN;
            end
            hed_pkg::PH_LEN:
            begin
                res.byte_position = 9'd2;
                if (keep == 8'd0)
                begin
                    res.end_of_packet = 1'b1;
                    res.packet_count  = hed_pkg::HDR_LEN;
                    index_next        = 9'd0;
                    left_next         = 8'd0;
                    phase_next        = hed_pkg::PH_HUNT;
                end
                else
                begin
                    index_next = hed_pkg::HDR_LEN;
                    left_next  = keep;
                    phase_next = hed_pkg::PH_PARAM;
                end
            end
            hed_pkg::PH_PARAM:
            begin
                res.byte_position = index_reg;
                if (left_reg <= 8'd1)
                begin
                    res.end_of_packet = 1'b1;
                    res.packet_count  = index_reg + 9'd1;
                    index_next        = 9'd0;
                    left_next         = 8'd0;
                    phase_next        = hed_pkg::PH_HUNT;
                end
                else
                begin
                    index_next = index_reg + 9'd1;
                    left_next  = left_reg - 8'd1;
                end
            end
            default:
            begin
                phase_next = hed_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= hed_pkg::PH_HUNT;
            index_reg   <= 9'd0;
            left_reg    <= 8'd0;
            bufsize_reg <= hed_pkg::BUF_SIZE_RESET;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                index_reg <= index_next;
                left_reg  <= left_next;
            end
            if (cfg_write)
            begin
                bufsize_reg <= cfg_data;
            end
        end
    end

endmodule

[rtl/hed_out_stage.sv]
module hed_out_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  hed_pkg::res_t res,
    output logic          out_busy,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    packet_byte,
    output logic [8:0]    byte_position,
    output logic          end_of_packet,
    output logic [8:0]    packet_count
);

    logic          valid_reg;
    logic          valid_next;
    hed_pkg::res_t data_reg;

    // A new result is only offered when the register is free or being drained.
    assign out_busy   = valid_reg && out_stall;
    assign valid_next = res.valid ? 1'b1 : (out_stall ? valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign packet_byte   = data_reg.packet_byte;
    assign byte_position = data_reg.byte_position;
    assign end_of_packet = data_reg.end_of_packet;
    assign packet_count  = data_reg.packet_count;

endmodule

[rtl/hci_event_packet_deframer.sv]
// Path: a byte accepted into the input register is processed by the state machine,
// and its result beat enters the result register when that register is free or
// being drained, so an output stall can hold the byte in the input register.
// Throughput: one byte per cycle while the result register is not held by an output stall.
// Reset (rst_n, asynchronous, active low) empties both registers, returns the
// deframer to hunting for the indicator and sets buffer_size to 258.
module hci_event_packet_deframer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_stall,
    input  logic [7:0] rx_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [8:0] cfg_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] packet_byte,
    output logic [8:0] byte_position,
    output logic       end_of_packet,
    output logic [8:0] packet_count
);

    // The input register holds one received beat. It frees itself as soon as
    // the state machine consumes the byte, so a new beat can enter every cycle
    // while the output register drains.
    logic          hold_valid;
    logic [7:0]    hold_byte;
    logic          take;
    logic          out_busy;
    hed_pkg::res_t res;

    // The buffer size register is always writable. It is sampled only when
    // a length byte is processed.
    assign cfg_ready = 1'b1;

    hed_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .take       (take),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    // The state machine hunts for the event indicator, passes the header and
    // then the kept parameter bytes. A dropped byte while hunting is consumed
    // even when the output register is full, since it produces no beat.
    hed_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte),
        .out_busy   (out_busy),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .take       (take),
        .res        (res)
    );

    // The result register keeps a finished beat stable while the consumer stalls.
    hed_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .res           (res),
        .out_busy      (out_busy),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .packet_byte   (packet_byte),
        .byte_position (byte_position),
        .end_of_packet (end_of_packet),
        .packet_count  (packet_count)
    );

endmodule

[rtl/hed_checker.sv]
module hed_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] packet_byte,
    input logic [8:0] byte_position,
    input logic       end_of_packet,
    input logic [8:0] packet_count
);

    // The final beat reports a total one past its own position.
    a_count_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_packet) |-> (packet_count == 9'(byte_position + 9'd1)))
        else $error("packet_count does not match last byte position");

    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !end_of_packet) |-> (packet_count == 9'd0))
        else $error("packet_count nonzero before end of packet");

    // A packet always opens with the event indicator and never ends on it.
    a_indicator: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (byte_position == 9'd0)) |->
        ((packet_byte == hed_pkg::IND_EVENT) && !end_of_packet))
        else $error("position zero is not the event indicator");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
        (out_valid && $stable(packet_byte) && $stable(byte_position)))
        else $error("stalled result beat changed");

endmodule

bind hci_event_packet_deframer hed_checker u_hed_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .packet_byte   (packet_byte),
    .byte_position (byte_position),
    .end_of_packet (end_of_packet),
    .packet_count  (packet_count)
);
